FILE: rtl/pswa_pkg.sv
// Shared types, codes and helpers of the priority scheduler with aging.
`default_nettype none
package pswa_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    // Input function codes
    localparam logic [1:0] FN_CREATE   = 2'd0;
    localparam logic [1:0] FN_TICK     = 2'd1;
    localparam logic [1:0] FN_BLOCK    = 2'd2;
    localparam logic [1:0] FN_ACTIVATE = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MEM_CAP  = 2'd0;
    localparam logic [1:0] CFG_PRN_CAP  = 2'd1;
    localparam logic [1:0] CFG_PREEMPT  = 2'd2;

    localparam logic [11:0] MEM_MAX = 12'hFFF;
    localparam logic [3:0]  PRN_MAX = 4'hF;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        K_EMPTY   = 2'd0,
        K_WAIT    = 2'd1,
        K_READY   = 2'd2,
        K_BLOCKED = 2'd3
    } t_kind;

    // Purpose of a best-priority scan
    typedef enum logic [1:0] {
        P_DISP   = 2'd0,
        P_REDISP = 2'd1,
        P_PRE    = 2'd2
    } t_pass;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_CR_FIND  = 16'h0002,
        ST_AGE_RD   = 16'h0004,
        ST_AGE_WR   = 16'h0008,
        ST_ADM_RD   = 16'h0010,
        ST_ADM_CHK  = 16'h0020,
        ST_ADM_END  = 16'h0040,
        ST_BEST_RD  = 16'h0080,
        ST_BEST_CHK = 16'h0100,
        ST_BEST_END = 16'h0200,
        ST_RUN_RD   = 16'h0400,
        ST_RUN_CHK  = 16'h0800,
        ST_ACT_RD   = 16'h1000,
        ST_ACT_CHK  = 16'h2000,
        ST_TEND     = 16'h4000,
        ST_DONE     = 16'h8000
    } t_state;

    // One table entry as held in the entry RAM
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] service;
        logic [15:0] remaining;
        logic [7:0]  prio;
        logic [15:0] waited;
        logic [11:0] mem;
        logic [3:0]  prn;
    } t_entry;

    // Base priority plus half the wait
    function automatic logic [15:0] eff_prio(t_entry e);
        return 16'(e.prio) + 16'(e.waited[15:1]);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pswa_ram.sv
// Generic simple dual-port RAM, one write port, registered read.
`default_nettype none
module pswa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/priority_scheduler_with_aging.sv
// Top level of the priority scheduler with aging: control sequencer and entry RAM.
`default_nettype none
// Task table of TABLE_ENTRIES entries; each entry's fields sit in one RAM word,
// the entry kinds (empty/waiting/ready/blocked) and one running slot in flops.
// One item at a time; every item gives exactly one result. A tick ages the
// table, runs the admission rounds, reads the running task, makes up to three
// best-priority scans and advances the tick. The entry RAM gives one entry per
// read and is scanned entry by entry for aging, for each admission round
// (oldest arrival first) and for every best-priority pick.
// Configuration writes are accepted only while idle; writing a capacity
// reloads the matching free count. No clearing pass is needed.
module priority_scheduler_with_aging #(
    parameter int TABLE_ENTRIES = pswa_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] arrival_time, [31:16] service_time, [39:32] base_priority,
    // [51:40] memory_request, [55:52] printer_request, [63:56] wake_id
    input  wire logic [63:0]  s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [7:0] new_id, [8] finished_valid, [16:9] finished_id,
    // [32:17] completion_time, [49:33] turnaround, [65:50] final_priority,
    // [66] running_valid, [74:67] running_id, [86:75] free_memory,
    // [90:87] free_printers, [106:91] current_tick, [111:107] zero
    output logic [111:0]      m_axis_tdata,
    // [1:0] status
    output logic [1:0]        m_axis_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [11:0]  i_cfg_data
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_ENTRIES);

    pswa_pkg::t_state n_state, r_state;
    pswa_pkg::t_kind  r_kind [TABLE_ENTRIES];
    logic             r_seen [TABLE_ENTRIES];
    pswa_pkg::t_pass  r_pass;

    logic [CNT_W-1:0] r_i;
    logic [IDX_W-1:0] ix;
    logic             at_end;

    logic             r_run;
    logic [IDX_W-1:0] r_ri;
    logic [7:0]       r_run_id;
    logic [15:0]      r_run_eff;
    logic [15:0]      r_tick;
    logic [7:0]       r_next_id;
    logic [11:0]      r_mem_free;
    logic [3:0]       r_prn_free;
    logic             r_preempt;

    // latched item
    logic [63:0]      r_in;

    // scan best
    logic             r_found;
    logic [IDX_W-1:0] r_bidx;
    logic [15:0]      r_beff;
    logic [7:0]       r_bid;
    logic [15:0]      r_barr;
    logic [11:0]      r_bmem;
    logic [3:0]       r_bprn;

    // result
    logic [1:0]       r_status;
    logic [7:0]       r_new_id;
    logic             r_fin_v;
    logic [7:0]       r_fin_id;
    logic [15:0]      r_fin_time;
    logic [16:0]      r_fin_turn;
    logic [15:0]      r_fin_prio;
    logic             r_m_valid;
    logic [111:0]     r_m_data;
    logic [1:0]       r_m_user;

    // RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    pswa_pkg::t_entry ram_wdata, rd;

    pswa_ram #(
        .WIDTH ($bits(pswa_pkg::t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign ix     = r_i[IDX_W-1:0];
    assign at_end = (r_i == LAST);

    pswa_pkg::t_kind cur_kind;
    logic            is_run_ix, age_cand, adm_cand, best_cand, act_cand;
    logic            res_short, adm_fit, beats;
    logic [15:0]     rd_eff;
    logic [12:0]     mem_sum;
    logic [4:0]      prn_sum;

    always_comb begin
        cur_kind  = r_kind[ix];
        is_run_ix = r_run && (r_ri == ix);
        age_cand  = (cur_kind == pswa_pkg::K_READY) || (cur_kind == pswa_pkg::K_BLOCKED);
        adm_cand  = (cur_kind == pswa_pkg::K_WAIT) && !r_seen[ix];
        best_cand = (cur_kind == pswa_pkg::K_READY) && !is_run_ix;
        act_cand  = (cur_kind == pswa_pkg::K_BLOCKED);
        res_short = (s_axis_tdata[51:40] > r_mem_free) || (s_axis_tdata[55:52] > r_prn_free);
        adm_fit   = (r_barr <= r_tick) && (r_bmem <= r_mem_free) && (r_bprn <= r_prn_free);
        beats     = r_found && (r_run_eff < r_beff);
        rd_eff    = pswa_pkg::eff_prio(rd);
        mem_sum   = 13'(r_mem_free) + 13'(rd.mem);
        prn_sum   = 5'(r_prn_free) + 5'(rd.prn);
    end

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ix;
        ram_raddr = (r_state == pswa_pkg::ST_RUN_RD) ? r_ri : ix;
        ram_wdata = rd;
        if (r_state == pswa_pkg::ST_AGE_WR) begin
            ram_we = 1'b1;
            if (((cur_kind == pswa_pkg::K_READY && !is_run_ix) ||
                 cur_kind == pswa_pkg::K_BLOCKED) && rd.waited != pswa_pkg::CNT_MAX) begin
                ram_wdata.waited = rd.waited + 16'd1;
            end
            if (is_run_ix && rd.remaining != 16'd0) begin
                ram_wdata.remaining = rd.remaining - 16'd1;
            end
        end else if (r_state == pswa_pkg::ST_CR_FIND && !at_end &&
                     cur_kind == pswa_pkg::K_EMPTY) begin
            ram_we              = 1'b1;
            ram_wdata.id        = r_next_id;
            ram_wdata.arrival   = r_in[15:0];
            ram_wdata.service   = r_in[31:16];
            ram_wdata.remaining = r_in[31:16];
            ram_wdata.prio      = r_in[39:32];
            ram_wdata.waited    = 16'd0;
            ram_wdata.mem       = r_in[51:40];
            ram_wdata.prn       = r_in[55:52];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pswa_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        pswa_pkg::FN_CREATE:
                            n_state = res_short ? pswa_pkg::ST_DONE : pswa_pkg::ST_CR_FIND;
                        pswa_pkg::FN_TICK:   n_state = pswa_pkg::ST_AGE_RD;
                        pswa_pkg::FN_BLOCK:  n_state = pswa_pkg::ST_DONE;
                        default:             n_state = pswa_pkg::ST_ACT_RD;
                    endcase
                end
            end
            pswa_pkg::ST_CR_FIND: begin
                if (at_end || cur_kind == pswa_pkg::K_EMPTY) n_state = pswa_pkg::ST_DONE;
            end
            pswa_pkg::ST_AGE_RD: begin
                if (at_end) n_state = pswa_pkg::ST_ADM_RD;
                else if (age_cand) n_state = pswa_pkg::ST_AGE_WR;
            end
            pswa_pkg::ST_AGE_WR: n_state = pswa_pkg::ST_AGE_RD;
            pswa_pkg::ST_ADM_RD: begin
                if (at_end) n_state = pswa_pkg::ST_ADM_END;
                else if (adm_cand) n_state = pswa_pkg::ST_ADM_CHK;
            end
            pswa_pkg::ST_ADM_CHK: n_state = pswa_pkg::ST_ADM_RD;
            pswa_pkg::ST_ADM_END: begin
                if (r_found) n_state = pswa_pkg::ST_ADM_RD;
                else if (r_run) n_state = pswa_pkg::ST_RUN_RD;
                else n_state = pswa_pkg::ST_BEST_RD;
            end
            pswa_pkg::ST_BEST_RD: begin
                if (at_end) n_state = pswa_pkg::ST_BEST_END;
                else if (best_cand) n_state = pswa_pkg::ST_BEST_CHK;
            end
            pswa_pkg::ST_BEST_CHK: n_state = pswa_pkg::ST_BEST_RD;
            pswa_pkg::ST_BEST_END: begin
                case (r_pass)
                    pswa_pkg::P_DISP:
                        n_state = r_found ? pswa_pkg::ST_RUN_RD : pswa_pkg::ST_TEND;
                    pswa_pkg::P_REDISP:
                        n_state = (r_found && r_preempt) ? pswa_pkg::ST_BEST_RD
                                                         : pswa_pkg::ST_TEND;
                    default: n_state = pswa_pkg::ST_TEND;
                endcase
            end
            pswa_pkg::ST_RUN_RD: n_state = pswa_pkg::ST_RUN_CHK;
            pswa_pkg::ST_RUN_CHK: begin
                if (rd.remaining == 16'd0 || r_preempt) n_state = pswa_pkg::ST_BEST_RD;
                else n_state = pswa_pkg::ST_TEND;
            end
            pswa_pkg::ST_ACT_RD: begin
                if (at_end) n_state = pswa_pkg::ST_DONE;
                else if (act_cand) n_state = pswa_pkg::ST_ACT_CHK;
            end
            pswa_pkg::ST_ACT_CHK: begin
                n_state = (rd.id == r_in[63:56]) ? pswa_pkg::ST_DONE : pswa_pkg::ST_ACT_RD;
            end
            pswa_pkg::ST_TEND: n_state = pswa_pkg::ST_DONE;
            pswa_pkg::ST_DONE: begin
                if (!r_m_valid || m_axis_tready) n_state = pswa_pkg::ST_IDLE;
            end
            default: n_state = pswa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pswa_pkg::ST_IDLE;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_kind[k] <= pswa_pkg::K_EMPTY;
                r_seen[k] <= 1'b0;
            end
            r_pass     <= pswa_pkg::P_DISP;
            r_i        <= '0;
            r_run      <= 1'b0;
            r_ri       <= '0;
            r_run_id   <= 8'd0;
            r_run_eff  <= 16'd0;
            r_tick     <= 16'd0;
            r_next_id  <= 8'd0;
            r_mem_free <= 12'd0;
            r_prn_free <= 4'd0;
            r_preempt  <= 1'b0;
            r_in       <= 64'd0;
            r_found    <= 1'b0;
            r_bidx     <= '0;
            r_beff     <= 16'd0;
            r_bid      <= 8'd0;
            r_barr     <= 16'd0;
            r_bmem     <= 12'd0;
            r_bprn     <= 4'd0;
            r_status   <= pswa_pkg::STAT_OK;
            r_new_id   <= 8'd0;
            r_fin_v    <= 1'b0;
            r_fin_id   <= 8'd0;
            r_fin_time <= 16'd0;
            r_fin_turn <= 17'd0;
            r_fin_prio <= 16'd0;
            r_m_valid  <= 1'b0;
            r_m_data   <= 112'd0;
            r_m_user   <= pswa_pkg::STAT_OK;
        end else begin
            r_state <= n_state;

            // only taken in idle, so never collides with the free-count updates below
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pswa_pkg::CFG_MEM_CAP: r_mem_free <= i_cfg_data;
                    pswa_pkg::CFG_PRN_CAP: r_prn_free <= i_cfg_data[3:0];
                    pswa_pkg::CFG_PREEMPT: r_preempt  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // in done the result register is reloaded instead
            if (r_m_valid && m_axis_tready && r_state != pswa_pkg::ST_DONE) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                pswa_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in       <= s_axis_tdata;
                        r_i        <= '0;
                        r_found    <= 1'b0;
                        r_new_id   <= 8'd0;
                        r_fin_v    <= 1'b0;
                        r_fin_id   <= 8'd0;
                        r_fin_time <= 16'd0;
                        r_fin_turn <= 17'd0;
                        r_fin_prio <= 16'd0;
                        for (int k = 0; k < TABLE_ENTRIES; k++) r_seen[k] <= 1'b0;
                        if (s_axis_tuser == pswa_pkg::FN_CREATE && res_short) begin
                            r_status <= pswa_pkg::STAT_SHORT;
                        end else if (s_axis_tuser == pswa_pkg::FN_BLOCK && !r_run) begin
                            r_status <= pswa_pkg::STAT_NONE;
                        end else begin
                            r_status <= pswa_pkg::STAT_OK;
                        end
                        if (s_axis_tuser == pswa_pkg::FN_BLOCK && r_run) begin
                            r_kind[r_ri] <= pswa_pkg::K_BLOCKED;
                            r_run        <= 1'b0;
                        end
                    end
                end
                pswa_pkg::ST_CR_FIND: begin
                    if (at_end) begin
                        r_status <= pswa_pkg::STAT_FULL;
                    end else if (cur_kind == pswa_pkg::K_EMPTY) begin
                        r_kind[ix] <= pswa_pkg::K_WAIT;
                        r_new_id   <= r_next_id;
                        r_next_id  <= r_next_id + 8'd1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                pswa_pkg::ST_AGE_RD: begin
                    if (at_end) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                    end else if (!age_cand) begin
                        r_i <= r_i + 1'b1;
                    end
                end
                pswa_pkg::ST_AGE_WR: r_i <= r_i + 1'b1;
                pswa_pkg::ST_ADM_RD: begin
                    if (!at_end && !adm_cand) r_i <= r_i + 1'b1;
                end
                pswa_pkg::ST_ADM_CHK: begin
                    // strict compare keeps the lower index on equal arrival
                    if (!r_found || rd.arrival < r_barr) begin
                        r_found <= 1'b1;
                        r_bidx  <= ix;
                        r_barr  <= rd.arrival;
                        r_bmem  <= rd.mem;
                        r_bprn  <= rd.prn;
                    end
                    r_i <= r_i + 1'b1;
                end
                pswa_pkg::ST_ADM_END: begin
                    if (r_found) begin
                        r_seen[r_bidx] <= 1'b1;
                        if (adm_fit) begin
                            r_mem_free     <= r_mem_free - r_bmem;
                            r_prn_free     <= r_prn_free - r_bprn;
                            r_kind[r_bidx] <= pswa_pkg::K_READY;
                        end
                    end
                    r_i     <= '0;
                    r_found <= 1'b0;
                    r_pass  <= pswa_pkg::P_DISP;
                end
                pswa_pkg::ST_BEST_RD: begin
                    if (!at_end && !best_cand) r_i <= r_i + 1'b1;
                end
                pswa_pkg::ST_BEST_CHK: begin
                    if (!r_found || rd_eff > r_beff) begin
                        r_found <= 1'b1;
                        r_bidx  <= ix;
                        r_beff  <= rd_eff;
                        r_bid   <= rd.id;
                    end
                    r_i <= r_i + 1'b1;
                end
                pswa_pkg::ST_BEST_END: begin
                    if (r_pass == pswa_pkg::P_PRE) begin
                        if (beats) begin
                            r_ri      <= r_bidx;
                            r_run_id  <= r_bid;
                        end
                    end else if (r_found) begin
                        r_run     <= 1'b1;
                        r_ri      <= r_bidx;
                        r_run_id  <= r_bid;
                        r_run_eff <= r_beff;
                    end
                    r_i     <= '0;
                    r_found <= 1'b0;
                    r_pass  <= pswa_pkg::P_PRE;
                end
                pswa_pkg::ST_RUN_RD: ;
                pswa_pkg::ST_RUN_CHK: begin
                    r_run_eff <= rd_eff;
                    r_i       <= '0;
                    r_found   <= 1'b0;
                    r_pass    <= (rd.remaining == 16'd0) ? pswa_pkg::P_REDISP
                                                         : pswa_pkg::P_PRE;
                    if (rd.remaining == 16'd0) begin
                        r_fin_v      <= 1'b1;
                        r_fin_id     <= rd.id;
                        r_fin_time   <= r_tick;
                        r_fin_turn   <= 17'(rd.waited) + 17'(rd.service);
                        r_fin_prio   <= rd_eff;
                        r_mem_free   <= mem_sum[12] ? pswa_pkg::MEM_MAX : mem_sum[11:0];
                        r_prn_free   <= prn_sum[4] ? pswa_pkg::PRN_MAX : prn_sum[3:0];
                        r_kind[r_ri] <= pswa_pkg::K_EMPTY;
                        r_run        <= 1'b0;
                    end
                end
                pswa_pkg::ST_ACT_RD: begin
                    if (at_end) r_status <= pswa_pkg::STAT_NONE;
                    else if (!act_cand) r_i <= r_i + 1'b1;
                end
                pswa_pkg::ST_ACT_CHK: begin
                    if (rd.id == r_in[63:56]) r_kind[ix] <= pswa_pkg::K_READY;
                    else r_i <= r_i + 1'b1;
                end
                pswa_pkg::ST_TEND: begin
                    if (r_tick != pswa_pkg::CNT_MAX) r_tick <= r_tick + 16'd1;
                end
                pswa_pkg::ST_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= r_status;
                        r_m_data  <= {5'd0, r_tick, r_prn_free, r_mem_free,
                                      (r_run ? r_run_id : 8'd0), r_run,
                                      r_fin_prio, r_fin_turn, r_fin_time, r_fin_id,
                                      r_fin_v, r_new_id};
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == pswa_pkg::ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign o_cfg_ready   = (r_state == pswa_pkg::ST_IDLE);

endmodule
`default_nettype wire

FILE: rtl/pswa_chk.sv
// Port-level checker of the priority scheduler with aging, bound to the top level.
`default_nettype none
module pswa_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [111:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser
);
    // one item in flight: no new item right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while previous item in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a finished task only comes with an ok status and without a new id
    a_fin_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |->
            m_axis_tuser == pswa_pkg::STAT_OK && m_axis_tdata[7:0] == 8'd0)
        else $error("finished task with bad status");

    a_run_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[66] |-> m_axis_tdata[74:67] == 8'd0)
        else $error("running id without running task");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[111:107] == 5'd0)
        else $error("pad bits set");
endmodule

bind priority_scheduler_with_aging pswa_chk u_pswa_chk (.*);
`default_nettype wire
